// ----- design/sequencing_read_base_encoder_defines.svh -----
// ----------------------------------------------------------------------------
// Sequencing read base encoder - assertion macros
// Shared concurrent check forms, sampled on clk, off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SEQUENCING_READ_BASE_ENCODER_DEFINES_SVH
`define SEQUENCING_READ_BASE_ENCODER_DEFINES_SVH

// condition holds at every edge
`define RBE_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("rbe: invariant check failed");

// consequent holds in the cycle after the antecedent
`define RBE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rbe: next-cycle check failed");

`endif

// ----- design/rbe_pkg.sv -----
// ----------------------------------------------------------------------------
// rbe_pkg
// Types, constants and coding functions of the read base encoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rbe_pkg;

  localparam int MAX_READ_LEN = 4096;
  localparam int LEN_W        = 13;
  localparam logic [LEN_W-1:0] LEN_MASK = {LEN_W{1'b1}};
  localparam int MAX_KEPT_I   = (MAX_READ_LEN > int'(LEN_MASK)) ? int'(LEN_MASK)
                                                                : MAX_READ_LEN;
  localparam logic [LEN_W-1:0] MAX_KEPT = LEN_W'(MAX_KEPT_I);

  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = LEN_W;
  localparam logic [CFG_ADDR_W-1:0] CFG_QUALITY  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_CONVERT  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_TRUNCATE = 2'd2;

  typedef enum logic [1:0] {
    QE_RAW    = 2'd0,
    QE_PLUS33 = 2'd1,
    QE_PLUS64 = 2'd2,
    QE_SOLEXA = 2'd3
  } qual_enc_t;

  localparam logic [2:0] CODE_A     = 3'd0;
  localparam logic [2:0] CODE_C     = 3'd1;
  localparam logic [2:0] CODE_G     = 3'd2;
  localparam logic [2:0] CODE_T     = 3'd3;
  localparam logic [2:0] CODE_OTHER = 3'd4;
  localparam logic [2:0] CODE_GAP   = 3'd5;

  localparam logic [7:0] PHRED33_OFS = 8'd33;
  localparam logic [7:0] PHRED64_OFS = 8'd64;
  localparam logic [7:0] SOLEXA_OFS  = 8'd10;
  localparam logic [7:0] SOLEXA_LIM  = 8'd20;

  localparam logic [3:0] SOLEXA_LOW [20] = '{
    4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd2, 4'd3,
    4'd3, 4'd4, 4'd4, 4'd5, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10
  };

  typedef struct packed {
    logic [2:0]       code;
    logic [7:0]       phred;
    logic [LEN_W-1:0] offset;
    logic [LEN_W-1:0] kept;
    logic             last;
  } rbe_item_t;

  function automatic logic [7:0] swap_base(input logic [7:0] c);
    logic [7:0] r;
    unique case (c)
      "A":     r = "T";
      "T":     r = "A";
      "C":     r = "G";
      "G":     r = "C";
      "a":     r = "t";
      "t":     r = "a";
      "c":     r = "g";
      "g":     r = "c";
      default: r = c;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] code_base(input logic [7:0] c);
    logic [2:0] r;
    unique case (c)
      "A", "a": r = CODE_A;
      "C", "c": r = CODE_C;
      "G", "g": r = CODE_G;
      "T", "t": r = CODE_T;
      "-":      r = CODE_GAP;
      default:  r = CODE_OTHER;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] to_phred(input qual_enc_t enc, input logic [7:0] q);
    logic [7:0] r;
    unique case (enc)
      QE_RAW:    r = q;
      QE_PLUS33: r = q - PHRED33_OFS;
      QE_PLUS64: r = q - PHRED64_OFS;
      QE_SOLEXA: r = (q < SOLEXA_LIM) ? {4'd0, SOLEXA_LOW[q[4:0]]} : q - SOLEXA_OFS;
      default:   r = q;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- design/rbe_front.sv -----
// ----------------------------------------------------------------------------
// rbe_front
// Holds configuration and base index; classifies each word and codes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rbe_front (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [rbe_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [rbe_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                           in_valid,
  input  wire logic [7:0]                     in_base_char,
  input  wire logic [7:0]                     in_quality_char,
  input  wire logic [rbe_pkg::LEN_W-1:0]      in_read_length,
  input  wire logic                           in_end_of_read,
  input  wire logic                           q_full,
  output logic                                push,
  output rbe_pkg::rbe_item_t                  push_item
);
  import rbe_pkg::*;

  qual_enc_t        qual_enc_r;
  logic [1:0]       conv_mode_r;
  logic [LEN_W-1:0] trunc_len_r;
  logic [LEN_W-1:0] base_index_r;
  logic [LEN_W-1:0] base_index_nxt;

  logic             accept;
  logic [LEN_W-1:0] kept;
  logic [LEN_W-1:0] kept_a;
  logic             keep;
  logic [7:0]       bc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qual_enc_r  <= QE_PLUS33;
      conv_mode_r <= 2'd0;
      trunc_len_r <= MAX_KEPT;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_QUALITY: begin
          qual_enc_r <= qual_enc_t'(cfg_wdata[1:0]);
        end
        CFG_CONVERT: begin
          conv_mode_r <= cfg_wdata[1:0];
        end
        CFG_TRUNCATE: begin
          trunc_len_r <= cfg_wdata;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    accept = in_valid && !q_full;
    kept_a = (trunc_len_r < in_read_length) ? trunc_len_r : in_read_length;
    kept   = (MAX_KEPT < kept_a) ? MAX_KEPT : kept_a;
    keep   = base_index_r < kept;
    bc     = conv_mode_r[0] ? swap_base(in_base_char) : in_base_char;

    push             = accept && keep;
    push_item.code   = code_base(bc);
    push_item.phred  = to_phred(qual_enc_r, in_quality_char);
    push_item.offset = conv_mode_r[1] ? (kept - base_index_r - LEN_W'(1)) : base_index_r;
    push_item.kept   = kept;
    push_item.last   = ({1'b0, base_index_r} + (LEN_W+1)'(1)) == {1'b0, kept};

    priority if (in_end_of_read) begin
      base_index_nxt = '0;
    end else if (base_index_r != LEN_MASK) begin
      base_index_nxt = base_index_r + LEN_W'(1);
    end else begin
      base_index_nxt = base_index_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_index_r <= '0;
    end else if (accept) begin
      base_index_r <= base_index_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- design/rbe_queue.sv -----
// ----------------------------------------------------------------------------
// rbe_queue
// Short FIFO of classified words between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "sequencing_read_base_encoder_defines.svh"

module rbe_queue (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire rbe_pkg::rbe_item_t push_item,
  output logic              full,
  input  wire logic         pop,
  output logic              pop_valid,
  output rbe_pkg::rbe_item_t pop_item
);
  import rbe_pkg::*;

  rbe_item_t        mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full      = count_r == CNT_W'(QUEUE_DEPTH);
  assign pop_valid = count_r != '0;
  assign pop_item  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      unique case ({push, pop})
        2'b10:   count_r <= count_r + CNT_W'(1);
        2'b01:   count_r <= count_r - CNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  `RBE_ASSERT_ALWAYS(a_count_bound, count_r <= CNT_W'(QUEUE_DEPTH))
  `RBE_ASSERT_ALWAYS(a_no_push_full, !(push && full))
  `RBE_ASSERT_ALWAYS(a_no_pop_empty, !(pop && !pop_valid))

endmodule

`default_nettype wire

// ----- design/rbe_back.sv -----
// ----------------------------------------------------------------------------
// rbe_back
// Applies stream position and read statistics; holds the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "sequencing_read_base_encoder_defines.svh"

module rbe_back (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      q_valid,
  input  wire rbe_pkg::rbe_item_t        q_item,
  output logic                           pop,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [2:0]                     out_base_code,
  output logic [7:0]                     out_phred_value,
  output logic [31:0]                    out_stream_position,
  output logic                           out_last_kept,
  output logic [31:0]                    out_reads_done,
  output logic [rbe_pkg::LEN_W-1:0]      out_shortest_read,
  output logic [rbe_pkg::LEN_W-1:0]      out_longest_read
);
  import rbe_pkg::*;

  logic [31:0]      stream_len_r;
  logic [31:0]      read_cnt_r;
  logic [LEN_W-1:0] min_len_r;
  logic [LEN_W-1:0] max_len_r;
  logic [31:0]      stream_len_nxt;
  logic [31:0]      read_cnt_nxt;
  logic [LEN_W-1:0] min_len_nxt;
  logic [LEN_W-1:0] max_len_nxt;
  logic             out_valid_r;

  logic [2:0]       code_r;
  logic [7:0]       phred_r;
  logic [31:0]      pos_r;
  logic             last_r;

  always_comb begin
    pop            = q_valid && (!out_valid_r || !out_stall);
    stream_len_nxt = stream_len_r;
    read_cnt_nxt   = read_cnt_r;
    min_len_nxt    = min_len_r;
    max_len_nxt    = max_len_r;
    if (q_item.last) begin
      stream_len_nxt = stream_len_r + 32'(q_item.kept);
      read_cnt_nxt   = read_cnt_r + 32'd1;
      if (q_item.kept < min_len_r) begin
        min_len_nxt = q_item.kept;
      end
      if (q_item.kept > max_len_r) begin
        max_len_nxt = q_item.kept;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stream_len_r <= '0;
      read_cnt_r   <= '0;
      min_len_r    <= LEN_MASK;
      max_len_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (pop) begin
        stream_len_r <= stream_len_nxt;
        read_cnt_r   <= read_cnt_nxt;
        min_len_r    <= min_len_nxt;
        max_len_r    <= max_len_nxt;
        out_valid_r  <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      code_r  <= q_item.code;
      phred_r <= q_item.phred;
      pos_r   <= stream_len_r + 32'(q_item.offset);
      last_r  <= q_item.last;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_base_code       = code_r;
  assign out_phred_value     = phred_r;
  assign out_stream_position = pos_r;
  assign out_last_kept       = last_r;
  assign out_reads_done      = read_cnt_r;
  assign out_shortest_read   = min_len_r;
  assign out_longest_read    = max_len_r;

  `RBE_ASSERT_NEXT(a_count_on_last, pop && q_item.last,
                   read_cnt_r == $past(read_cnt_r) + 32'd1)
  `RBE_ASSERT_NEXT(a_len_hold_mid, pop && !q_item.last,
                   $stable(stream_len_r) && $stable(read_cnt_r))
  `RBE_ASSERT_ALWAYS(a_min_le_max, (max_len_r == '0) || (min_len_r <= max_len_r))

endmodule

`default_nettype wire

// ----- design/sequencing_read_base_encoder.sv -----
// ----------------------------------------------------------------------------
// sequencing_read_base_encoder
// Base and quality coder: truncation, complement, 3-bit code, Phred
// conversion, stream position and read length statistics.
//
//   channel | direction | handshake            | words
//   in_     | input     | in_valid / in_stall  | base, quality, length, end
//   out_    | output    | out_valid / out_stall| code, phred, position, stats
//   cfg_    | input     | cfg_we               | register index and data
//
// One word per cycle while out_stall is low; a kept word passes from the front
// classify into the queue and then into the back result register to reach out_.
// The two-entry queue sets the stall slack: in_stall rises only when it is full.
// Dropped words (beyond the kept length) update the base index and give nothing.
// Reset is synchronous on rst_n low and needs no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sequencing_read_base_encoder (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [rbe_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [rbe_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [7:0]                     in_base_char,
  input  wire logic [7:0]                     in_quality_char,
  input  wire logic [rbe_pkg::LEN_W-1:0]      in_read_length,
  input  wire logic                           in_end_of_read,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [2:0]                          out_base_code,
  output logic [7:0]                          out_phred_value,
  output logic [31:0]                         out_stream_position,
  output logic                                out_last_kept,
  output logic [31:0]                         out_reads_done,
  output logic [rbe_pkg::LEN_W-1:0]           out_shortest_read,
  output logic [rbe_pkg::LEN_W-1:0]           out_longest_read
);
  import rbe_pkg::*;

  logic      q_full;
  logic      push;
  rbe_item_t push_item;
  logic      pop;
  logic      q_valid;
  rbe_item_t q_item;

  assign in_stall = q_full;

  rbe_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_base_char   (in_base_char),
    .in_quality_char(in_quality_char),
    .in_read_length (in_read_length),
    .in_end_of_read (in_end_of_read),
    .q_full         (q_full),
    .push           (push),
    .push_item      (push_item)
  );

  rbe_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_item(push_item),
    .full     (q_full),
    .pop      (pop),
    .pop_valid(q_valid),
    .pop_item (q_item)
  );

  rbe_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (q_valid),
    .q_item             (q_item),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_base_code      (out_base_code),
    .out_phred_value    (out_phred_value),
    .out_stream_position(out_stream_position),
    .out_last_kept      (out_last_kept),
    .out_reads_done     (out_reads_done),
    .out_shortest_read  (out_shortest_read),
    .out_longest_read   (out_longest_read)
  );

endmodule

`default_nettype wire
